[hw/rtl/pmpo_pkg.sv]
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT package
// Shared widths, reset values, register indexes and stage types.
// ----------------------------------------------------------------------------
package pmpo_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int COMPARE_MAX = 255;
   localparam int COMPARE_BITS = $clog2(COMPARE_MAX + 1);
   localparam int POWER_BITS = 2 * SAMPLE_BITS;

   localparam int SAMPLE_FIELD_BITS = 10;
   localparam int COMPARE_FIELD_BITS = 8;
   localparam int POWER_FIELD_BITS = 20;

   localparam int THRESHOLD_BITS = 10;
   localparam int MIN_POWER_BITS = 20;
   localparam int COUNT_BITS = 16;
   localparam int CSR_DATA_BITS = 20;
   localparam int CSR_INDEX_BITS = 2;

   localparam int THR_CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;
   localparam int PWR_CMP_BITS = (POWER_BITS > MIN_POWER_BITS) ? POWER_BITS : MIN_POWER_BITS;

   localparam logic [COMPARE_BITS-1:0] COMPARE_TOP = COMPARE_BITS'(COMPARE_MAX);

   localparam logic [THRESHOLD_BITS-1:0] LOW_CELL_RESET = THRESHOLD_BITS'(202);
   localparam logic [THRESHOLD_BITS-1:0] BATTERY_FULL_RESET = THRESHOLD_BITS'(680);
   localparam logic [MIN_POWER_BITS-1:0] MIN_POWER_RESET = MIN_POWER_BITS'(2000);
   localparam logic [COUNT_BITS-1:0] SLEEP_LIMIT_RESET = COUNT_BITS'(60000);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOW_CELL_THRESHOLD = 2'd0,
      CSR_BATTERY_FULL_THRESHOLD = 2'd1,
      CSR_MIN_POWER = 2'd2,
      CSR_SLEEP_COUNT_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] low_cell_threshold;
      logic [THRESHOLD_BITS-1:0] battery_full_threshold;
      logic [MIN_POWER_BITS-1:0] min_power;
      logic [COUNT_BITS-1:0] sleep_count_limit;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] panel_volt;
      logic [SAMPLE_BITS-1:0] panel_curr;
      logic [SAMPLE_BITS-1:0] battery_voltage;
   } sample_type;

   typedef struct packed {
      logic advance;
      logic sleeping;
   } step_status_type;

endpackage

[hw/rtl/pmpo_if.sv]
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT channel interfaces
// Valid/ready channels for sample sets and step results.
// ----------------------------------------------------------------------------
interface pmpo_req_if;
   logic valid;
   logic ready;
   logic [pmpo_pkg::SAMPLE_FIELD_BITS-1:0] cell_voltage_sample;
   logic [pmpo_pkg::SAMPLE_FIELD_BITS-1:0] cell_current_sample;
   logic [pmpo_pkg::SAMPLE_FIELD_BITS-1:0] battery_voltage_sample;

   modport source (
      output valid, cell_voltage_sample, cell_current_sample, battery_voltage_sample,
      input ready
   );
   modport sink (
      input valid, cell_voltage_sample, cell_current_sample, battery_voltage_sample,
      output ready
   );
endinterface

interface pmpo_rsp_if;
   logic valid;
   logic ready;
   logic [pmpo_pkg::COMPARE_FIELD_BITS-1:0] pwm_compare;
   logic pwm_enabled;
   logic [pmpo_pkg::POWER_FIELD_BITS-1:0] power_measure;

   modport source (
      output valid, pwm_compare, pwm_enabled, power_measure,
      input ready
   );
   modport sink (
      input valid, pwm_compare, pwm_enabled, power_measure,
      output ready
   );
endinterface

[hw/rtl/pmpo_csr.sv]
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT configuration registers
// Write-only threshold and limit registers with reset defaults.
// ----------------------------------------------------------------------------
module pmpo_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [pmpo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pmpo_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   output pmpo_pkg::cfg_type cfg
);

   pmpo_pkg::cfg_type cfg_ff;
   pmpo_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (pmpo_pkg::csr_index_type'(csr_index))
            pmpo_pkg::CSR_LOW_CELL_THRESHOLD: begin
               cfg_in.low_cell_threshold = csr_write_data[pmpo_pkg::THRESHOLD_BITS-1:0];
            end
            pmpo_pkg::CSR_BATTERY_FULL_THRESHOLD: begin
               cfg_in.battery_full_threshold = csr_write_data[pmpo_pkg::THRESHOLD_BITS-1:0];
            end
            pmpo_pkg::CSR_MIN_POWER: begin
               cfg_in.min_power = csr_write_data[pmpo_pkg::MIN_POWER_BITS-1:0];
            end
            pmpo_pkg::CSR_SLEEP_COUNT_LIMIT: begin
               cfg_in.sleep_count_limit = csr_write_data[pmpo_pkg::COUNT_BITS-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_cell_threshold <= pmpo_pkg::LOW_CELL_RESET;
         cfg_ff.battery_full_threshold <= pmpo_pkg::BATTERY_FULL_RESET;
         cfg_ff.min_power <= pmpo_pkg::MIN_POWER_RESET;
         cfg_ff.sleep_count_limit <= pmpo_pkg::SLEEP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/pmpo_input_stage.sv]
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT input stage
// Registers one sample set beat and holds it until the step stage takes it.
// ----------------------------------------------------------------------------
module pmpo_input_stage (
   input  logic clock,
   input  logic reset,
   pmpo_req_if.sink req_chan,
   input  logic advance,
   output pmpo_pkg::sample_type sample,
   output logic sample_valid
);

   logic valid_ff;
   logic valid_in;
   pmpo_pkg::sample_type sample_ff;
   pmpo_pkg::sample_type sample_in;
   logic take;

   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      sample_in = sample_ff;
      if (take) begin
         valid_in = 1'b1;
         sample_in.panel_volt = pmpo_pkg::SAMPLE_BITS'(req_chan.cell_voltage_sample);
         sample_in.panel_curr = pmpo_pkg::SAMPLE_BITS'(req_chan.cell_current_sample);
         sample_in.battery_voltage = pmpo_pkg::SAMPLE_BITS'(req_chan.battery_voltage_sample);
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample = sample_ff;
   assign sample_valid = valid_ff;

endmodule

[hw/rtl/pmpo_step.sv]
// ----------------------------------------------------------------------------
// Perturb-and-observe MPPT step stage
// Forms power, steps the compare value, tracks sleep, registers the result.
// ----------------------------------------------------------------------------
module pmpo_step (
   input  logic clock,
   input  logic reset,
   input  pmpo_pkg::cfg_type cfg,
   input  pmpo_pkg::sample_type sample,
   input  logic sample_valid,
   pmpo_rsp_if.source rsp_chan,
   output pmpo_pkg::step_status_type status
);

   logic [pmpo_pkg::COMPARE_BITS-1:0] compare_ff, compare_in;
   logic [pmpo_pkg::POWER_BITS-1:0] prev_power_ff, prev_power_in;
   logic [pmpo_pkg::SAMPLE_BITS-1:0] prev_voltage_ff, prev_voltage_in;
   logic [pmpo_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic sleeping_ff, sleeping_in;

   logic out_valid_ff, out_valid_in;
   logic [pmpo_pkg::COMPARE_FIELD_BITS-1:0] out_compare_ff, out_compare_in;
   logic out_enabled_ff, out_enabled_in;
   logic [pmpo_pkg::POWER_FIELD_BITS-1:0] out_power_ff, out_power_in;

   logic advance;
   logic [pmpo_pkg::POWER_BITS-1:0] power;
   logic [pmpo_pkg::THR_CMP_BITS-1:0] volt_cmp, batt_cmp, low_cmp, full_cmp;
   logic [pmpo_pkg::COUNT_BITS-1:0] count_inc;
   logic forced, power_rose, volt_rose, step_down, low_power;

   assign advance = sample_valid && (!out_valid_ff || rsp_chan.ready);

   assign power = pmpo_pkg::POWER_BITS'(sample.panel_volt)
      * pmpo_pkg::POWER_BITS'(sample.panel_curr);
   assign volt_cmp = pmpo_pkg::THR_CMP_BITS'(sample.panel_volt);
   assign batt_cmp = pmpo_pkg::THR_CMP_BITS'(sample.battery_voltage);
   assign low_cmp = pmpo_pkg::THR_CMP_BITS'(cfg.low_cell_threshold);
   assign full_cmp = pmpo_pkg::THR_CMP_BITS'(cfg.battery_full_threshold);
   assign forced = (volt_cmp < low_cmp) || (batt_cmp > full_cmp);
   assign power_rose = power > prev_power_ff;
   assign volt_rose = sample.panel_volt > prev_voltage_ff;
   assign step_down = !forced && (power_rose == volt_rose);
   assign low_power = pmpo_pkg::PWR_CMP_BITS'(power) < pmpo_pkg::PWR_CMP_BITS'(cfg.min_power);
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      compare_in = compare_ff;
      prev_power_in = prev_power_ff;
      prev_voltage_in = prev_voltage_ff;
      count_in = count_ff;
      sleeping_in = sleeping_ff;
      out_enabled_in = 1'b0;
      out_power_in = '0;
      if (sleeping_ff) begin
         if (volt_cmp >= low_cmp) begin
            sleeping_in = 1'b0;
            compare_in = pmpo_pkg::COMPARE_TOP;
            out_enabled_in = 1'b1;
         end
      end else begin
         if (step_down) begin
            if (compare_ff != '0) begin
               compare_in = compare_ff - 1'b1;
            end
         end else if (compare_ff < pmpo_pkg::COMPARE_TOP) begin
            compare_in = compare_ff + 1'b1;
         end
         prev_power_in = power;
         prev_voltage_in = sample.panel_volt;
         out_enabled_in = 1'b1;
         out_power_in = pmpo_pkg::POWER_FIELD_BITS'(power);
         if (low_power) begin
            count_in = count_inc;
            if (count_inc > cfg.sleep_count_limit) begin
               count_in = '0;
               sleeping_in = 1'b1;
               out_enabled_in = 1'b0;
            end
         end else begin
            count_in = '0;
         end
      end
      out_compare_in = pmpo_pkg::COMPARE_FIELD_BITS'(compare_in);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= pmpo_pkg::COMPARE_TOP;
         prev_power_ff <= '0;
         prev_voltage_ff <= '0;
         count_ff <= '0;
         sleeping_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            compare_ff <= compare_in;
            prev_power_ff <= prev_power_in;
            prev_voltage_ff <= prev_voltage_in;
            count_ff <= count_in;
            sleeping_ff <= sleeping_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_compare_ff <= out_compare_in;
         out_enabled_ff <= out_enabled_in;
         out_power_ff <= out_power_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pwm_compare = out_compare_ff;
   assign rsp_chan.pwm_enabled = out_enabled_ff;
   assign rsp_chan.power_measure = out_power_ff;

   assign status.advance = advance;
   assign status.sleeping = sleeping_ff;

endmodule

[hw/rtl/solar_mppt_perturb_observe_core.sv]
// ----------------------------------------------------------------------------
// Solar perturb-and-observe MPPT core
// Each sample beat is registered in the input stage, then its result beat in the step stage's output register.
// Throughput: one sample beat per cycle while the result channel is not stalled.
// A stalled result holds its register while the input register takes one more beat.
// Synchronous reset restores default registers, compare value at maximum, running.
// ----------------------------------------------------------------------------
module solar_mppt_perturb_observe_core (
   input  logic clock,
   input  logic reset,
   pmpo_req_if.sink req_chan,
   pmpo_rsp_if.source rsp_chan,
   input  logic csr_write_enable,
   input  logic [pmpo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pmpo_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   pmpo_pkg::cfg_type cfg;
   pmpo_pkg::sample_type sample;
   logic sample_valid;
   pmpo_pkg::step_status_type status;

   pmpo_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   pmpo_input_stage u_input_stage (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .advance(status.advance),
      .sample(sample),
      .sample_valid(sample_valid)
   );

   pmpo_step u_step (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .sample(sample),
      .sample_valid(sample_valid),
      .rsp_chan(rsp_chan),
      .status(status)
   );

`ifndef SYNTH
   // Every step taken shows up as a result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      status.advance |=> rsp_chan.valid)
      else $error("step taken without a result beat");

   // A step taken while asleep never reports power.
   assert property (@(posedge clock) disable iff (reset)
      (status.advance && status.sleeping) |=> (rsp_chan.power_measure == '0))
      else $error("sleeping step reported nonzero power");

   // Waking resumes PWM at the top compare value.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(status.sleeping) && rsp_chan.valid) |->
         (rsp_chan.pwm_enabled && (rsp_chan.pwm_compare ==
            pmpo_pkg::COMPARE_FIELD_BITS'(pmpo_pkg::COMPARE_MAX))))
      else $error("wake step did not restart at top compare value");
`endif

endmodule

[verif/tb_solar_mppt_perturb_observe_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the solar perturb-and-observe MPPT core
// Drives sample-set beats and settings, tracks the expected step of each
// beat in a scoreboard class and compares every result beat field by field.
// Covers forced rise, saturation at both ends, sleep entry and wake, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_solar_mppt_perturb_observe_core;

   typedef struct packed {
      logic [pmpo_pkg::COMPARE_FIELD_BITS-1:0] pwm_compare;
      logic pwm_enabled;
      logic [pmpo_pkg::POWER_FIELD_BITS-1:0] power_measure;
   } step_result_type;

   class mppt_step_checker;
      logic [pmpo_pkg::THRESHOLD_BITS-1:0] low_cell_thr;
      logic [pmpo_pkg::THRESHOLD_BITS-1:0] batt_full_thr;
      logic [pmpo_pkg::MIN_POWER_BITS-1:0] min_pwr;
      logic [pmpo_pkg::COUNT_BITS-1:0] sleep_limit;
      logic [pmpo_pkg::COMPARE_FIELD_BITS-1:0] duty;
      logic [pmpo_pkg::POWER_FIELD_BITS-1:0] last_power;
      logic [pmpo_pkg::SAMPLE_BITS-1:0] last_volt;
      logic [pmpo_pkg::COUNT_BITS-1:0] low_count;
      bit asleep;
      step_result_type expected_steps[$];
      int failures;
      int results_checked;

      function new();
         low_cell_thr = pmpo_pkg::LOW_CELL_RESET;
         batt_full_thr = pmpo_pkg::BATTERY_FULL_RESET;
         min_pwr = pmpo_pkg::MIN_POWER_RESET;
         sleep_limit = pmpo_pkg::SLEEP_LIMIT_RESET;
         duty = pmpo_pkg::COMPARE_FIELD_BITS'(pmpo_pkg::COMPARE_MAX);
         last_power = '0;
         last_volt = '0;
         low_count = '0;
         asleep = 1'b0;
         failures = 0;
         results_checked = 0;
      endfunction

      function void set_register(input pmpo_pkg::csr_index_type idx,
                                 input logic [pmpo_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            pmpo_pkg::CSR_LOW_CELL_THRESHOLD:
               low_cell_thr = value[pmpo_pkg::THRESHOLD_BITS-1:0];
            pmpo_pkg::CSR_BATTERY_FULL_THRESHOLD:
               batt_full_thr = value[pmpo_pkg::THRESHOLD_BITS-1:0];
            pmpo_pkg::CSR_MIN_POWER: min_pwr = value[pmpo_pkg::MIN_POWER_BITS-1:0];
            pmpo_pkg::CSR_SLEEP_COUNT_LIMIT: sleep_limit = value[pmpo_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void nudge_duty(input bit rise);
         if (rise) begin
            if (duty < pmpo_pkg::COMPARE_MAX) duty++;
         end else if (duty > 0) begin
            duty--;
         end
      endfunction

      function void note_sample(input pmpo_pkg::sample_type s);
         logic [pmpo_pkg::POWER_FIELD_BITS-1:0] pwr;
         logic on;
         pwr = '0;
         on = 1'b1;
         if (asleep) begin
            if (s.panel_volt >= low_cell_thr) begin
               asleep = 1'b0;
               duty = pmpo_pkg::COMPARE_FIELD_BITS'(pmpo_pkg::COMPARE_MAX);
            end else begin
               on = 1'b0;
            end
         end else begin
            pwr = s.panel_volt * s.panel_curr;
            if (s.panel_volt < low_cell_thr || s.battery_voltage > batt_full_thr) begin
               nudge_duty(1'b1);
            end else if (pwr > last_power) begin
               nudge_duty(!(s.panel_volt > last_volt));
            end else begin
               nudge_duty(!(s.panel_volt <= last_volt));
            end
            last_power = pwr;
            last_volt = s.panel_volt;
            if (pwr < min_pwr) begin
               low_count = low_count + 1'b1;
               if (low_count > sleep_limit) begin
                  low_count = '0;
                  asleep = 1'b1;
                  on = 1'b0;
               end
            end else begin
               low_count = '0;
            end
         end
         expected_steps.push_back({duty, on, pwr});
      endfunction

      task report_mismatch(input string msg);
         failures++;
         if (failures <= 100) $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_result(input logic [pmpo_pkg::COMPARE_FIELD_BITS-1:0] cmp, input logic en,
                        input logic [pmpo_pkg::POWER_FIELD_BITS-1:0] pwr);
         step_result_type want;
         results_checked++;
         if (expected_steps.size() == 0) begin
            report_mismatch("result beat arrived with no sample beat outstanding");
            return;
         end
         want = expected_steps.pop_front();
         if (cmp !== want.pwm_compare)
            report_mismatch($sformatf("beat %0d: pwm_compare %0d, expected %0d",
                                      results_checked, cmp, want.pwm_compare));
         if (en !== want.pwm_enabled)
            report_mismatch($sformatf("beat %0d: pwm_enabled %b, expected %b",
                                      results_checked, en, want.pwm_enabled));
         if (pwr !== want.power_measure)
            report_mismatch($sformatf("beat %0d: power_measure %0d, expected %0d",
                                      results_checked, pwr, want.power_measure));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [pmpo_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [pmpo_pkg::CSR_DATA_BITS-1:0] csr_write_data;
   bit steady_flow;
   int beats_sent;
   pmpo_pkg::sample_type last_sample;
   mppt_step_checker sb;

   pmpo_req_if req_chan();
   pmpo_rsp_if rsp_chan();

   solar_mppt_perturb_observe_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= steady_flow || ($urandom_range(0, 99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_sample({req_chan.cell_voltage_sample, req_chan.cell_current_sample,
                            req_chan.battery_voltage_sample});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.pwm_compare, rsp_chan.pwm_enabled, rsp_chan.power_measure);
      end
   end

   task automatic send_sample(input logic [pmpo_pkg::SAMPLE_BITS-1:0] cv,
                              input logic [pmpo_pkg::SAMPLE_BITS-1:0] cc,
                              input logic [pmpo_pkg::SAMPLE_BITS-1:0] bv);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 14) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.cell_voltage_sample <= cv;
      req_chan.cell_current_sample <= cc;
      req_chan.battery_voltage_sample <= bv;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      beats_sent++;
   endtask

   // Holds the sender off until every result beat has been checked.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.results_checked < beats_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [pmpo_pkg::THRESHOLD_BITS-1:0] lc,
                                 input logic [pmpo_pkg::THRESHOLD_BITS-1:0] bf,
                                 input logic [pmpo_pkg::MIN_POWER_BITS-1:0] mp,
                                 input logic [pmpo_pkg::COUNT_BITS-1:0] lim);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= pmpo_pkg::CSR_LOW_CELL_THRESHOLD;
      csr_write_data <= pmpo_pkg::CSR_DATA_BITS'(lc);
      @(posedge clock);
      csr_index <= pmpo_pkg::CSR_BATTERY_FULL_THRESHOLD;
      csr_write_data <= pmpo_pkg::CSR_DATA_BITS'(bf);
      @(posedge clock);
      csr_index <= pmpo_pkg::CSR_MIN_POWER;
      csr_write_data <= pmpo_pkg::CSR_DATA_BITS'(mp);
      @(posedge clock);
      csr_index <= pmpo_pkg::CSR_SLEEP_COUNT_LIMIT;
      csr_write_data <= pmpo_pkg::CSR_DATA_BITS'(lim);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(pmpo_pkg::CSR_LOW_CELL_THRESHOLD, pmpo_pkg::CSR_DATA_BITS'(lc));
      sb.set_register(pmpo_pkg::CSR_BATTERY_FULL_THRESHOLD, pmpo_pkg::CSR_DATA_BITS'(bf));
      sb.set_register(pmpo_pkg::CSR_MIN_POWER, pmpo_pkg::CSR_DATA_BITS'(mp));
      sb.set_register(pmpo_pkg::CSR_SLEEP_COUNT_LIMIT, pmpo_pkg::CSR_DATA_BITS'(lim));
   endtask

   function automatic logic [pmpo_pkg::SAMPLE_BITS-1:0] clamp_code(input int x);
      if (x < 0) return '0;
      if (x > 1023) return pmpo_pkg::SAMPLE_BITS'(1023);
      return pmpo_pkg::SAMPLE_BITS'(x);
   endfunction

   // Mostly a slow walk around an operating point, with threshold hits,
   // repeated sample sets and pure noise mixed in.
   function automatic pmpo_pkg::sample_type next_sample();
      pmpo_pkg::sample_type s;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      s = last_sample;
      if (pick < 12) begin
         s.panel_volt = pmpo_pkg::SAMPLE_BITS'($urandom);
         s.panel_curr = pmpo_pkg::SAMPLE_BITS'($urandom);
         s.battery_voltage = pmpo_pkg::SAMPLE_BITS'($urandom);
      end else if (pick < 24) begin
         s.panel_volt = clamp_code(int'(sb.low_cell_thr) + int'($urandom_range(0, 2)) - 1);
         s.panel_curr = pmpo_pkg::SAMPLE_BITS'($urandom);
         s.battery_voltage =
            clamp_code(int'(sb.batt_full_thr) + int'($urandom_range(0, 2)) - 1);
      end else if (pick >= 32) begin
         s.panel_volt = clamp_code(int'(s.panel_volt) + int'($urandom_range(0, 24)) - 12);
         s.panel_curr = clamp_code(int'(s.panel_curr) + int'($urandom_range(0, 24)) - 12);
         if ($urandom_range(0, 3) == 0) s.battery_voltage = pmpo_pkg::SAMPLE_BITS'($urandom);
      end
      last_sample = s;
      return s;
   endfunction

   initial begin
      #10_000_000;
      $display("solar_mppt_perturb_observe_core test failed");
      $finish;
   end

   initial begin
      pmpo_pkg::sample_type s;
      int count;
      logic [pmpo_pkg::SAMPLE_BITS-1:0] hold_v;
      logic [pmpo_pkg::SAMPLE_BITS-1:0] hold_i;
      logic [pmpo_pkg::SAMPLE_BITS-1:0] hold_b;
      sb = new();
      beats_sent = 0;
      steady_flow = 1'b0;
      last_sample = {10'd400, 10'd300, 10'd300};
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cell_voltage_sample <= '0;
      req_chan.cell_current_sample <= '0;
      req_chan.battery_voltage_sample <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= pmpo_pkg::CSR_LOW_CELL_THRESHOLD;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: forced rise, every perturb-and-observe branch and
      // the threshold boundaries.
      send_sample(10'd0, 10'd0, 10'd0);
      send_sample(10'd1023, 10'd1023, 10'd1023);
      send_sample(10'd1023, 10'd1023, 10'd680);
      send_sample(10'd1023, 10'd1000, 10'd0);
      send_sample(10'd900, 10'd1023, 10'd0);
      send_sample(10'd950, 10'd1023, 10'd0);
      send_sample(10'd1000, 10'd500, 10'd0);
      send_sample(10'd800, 10'd1000, 10'd0);
      send_sample(10'd202, 10'd1023, 10'd0);
      send_sample(10'd201, 10'd1023, 10'd681);
      send_sample(10'd202, 10'd0, 10'd0);

      // Sleep entry, staying asleep, wake at the threshold and a quick return.
      apply_settings(10'd300, 10'd1023, 20'hFFFFF, 16'd1);
      send_sample(10'd400, 10'd5, 10'd0);
      send_sample(10'd500, 10'd5, 10'd0);
      send_sample(10'd299, 10'd1023, 10'd1023);
      send_sample(10'd0, 10'd0, 10'd1023);
      send_sample(10'd300, 10'd7, 10'd0);
      send_sample(10'd1023, 10'd1023, 10'd1023);
      send_sample(10'd1023, 10'd1023, 10'd0);
      send_sample(10'd1023, 10'd0, 10'd0);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_settings(10'd0, 10'd1023, 20'd0, 16'hFFFF);
            1: apply_settings(10'd1023, 10'd0, 20'd1046529, 16'd0);
            default: apply_settings(pmpo_pkg::THRESHOLD_BITS'($urandom_range(100, 500)),
                                    pmpo_pkg::THRESHOLD_BITS'($urandom_range(500, 1023)),
                                    pmpo_pkg::MIN_POWER_BITS'($urandom_range(0, 300000)),
                                    pmpo_pkg::COUNT_BITS'($urandom_range(0, 6)));
         endcase
         steady_flow = (ph == 3);
         count = $urandom_range(70, 90);
         repeat (count) begin
            s = next_sample();
            send_sample(s.panel_volt, s.panel_curr, s.battery_voltage);
         end
      end
      steady_flow = 1'b0;

      // A constant sample set keeps lowering the compare value down to zero.
      apply_settings(10'd0, 10'd1023, 20'hFFFFF, 16'hFFFF);
      hold_v = pmpo_pkg::SAMPLE_BITS'($urandom_range(1, 1023));
      hold_i = pmpo_pkg::SAMPLE_BITS'($urandom);
      hold_b = pmpo_pkg::SAMPLE_BITS'($urandom);
      repeat (300) send_sample(hold_v, hold_i, hold_b);
      apply_settings(10'd0, 10'd1023, 20'hFFFFF, 16'd3);
      repeat (8) begin
         s = next_sample();
         send_sample(s.panel_volt, s.panel_curr, s.battery_voltage);
      end

      settle();
      if (sb.failures == 0) begin
         $display("solar_mppt_perturb_observe_core test passed");
      end else begin
         $display("solar_mppt_perturb_observe_core test failed");
      end
      $finish;
   end

endmodule
